/* rtl/scba_pkg.sv */
package scba_pkg;

  localparam int GRANULE_INDEX_BITS = 16;
  localparam int CLASS_COUNT = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_BITS = 32;
  localparam int SIZE_BITS = 27;
  localparam int CLASS_BITS = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int HDR_BYTES = 16;
  localparam int WINDOW_BYTES = 4 * 1024 * 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_SIZE      = 2'd1,
    STATUS_NO_MEMORY = 2'd2,
    STATUS_NO_HEAP   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] region_start;
    logic [ADDR_BITS-1:0] region_limit;
    logic [ADDR_BITS-1:0] frame_window_start;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic                  too_large;
    logic [CLASS_BITS-1:0] class_id;
    logic                  granule_ok;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_BITS-1:0] size;
    status_t              status;
  } result_t;

  function automatic logic [SIZE_BITS-1:0] class_bytes(input logic [CLASS_BITS-1:0] k);
    logic [SIZE_BITS-1:0] b;
    case (k)
      4'd0:    b = 27'h40;
      4'd1:    b = 27'h400;
      4'd2:    b = 27'h1000;
      4'd3:    b = 27'h4000;
      4'd4:    b = 27'h8000;
      4'd5:    b = 27'h40000;
      4'd6:    b = 27'h80000;
      4'd7:    b = 27'h100000;
      4'd8:    b = 27'h200000;
      4'd9:    b = 27'h400000;
      4'd10:   b = 27'h800000;
      4'd11:   b = 27'h1000000;
      4'd12:   b = 27'h2000000;
      4'd13:   b = 27'h4000000;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/size_class_block_allocator_unit.sv */
// Size-class block allocator: 64 B to 64 MB classes, each with a LIFO free
// list, plus a bump pointer that skips a 4 MB frame-buffer window. Requests
// enter a two-entry command queue after size classification and leave through
// a two-entry result queue, one result per request, in order. The execution
// unit handles one request at a time: an allocate served from a free list
// does a head lookup, then the registered link read; an allocate that bumps
// is accepted, then checks the window, then checks the limit and header store
// with the class write; a free whose header falls inside the store does a
// registered class read, then the list push when the class is valid; and a
// size or no-heap error, or a free outside the store, is answered when it
// is accepted. After reset the block runs a clearing pass over all
// 2^GRANULE_INDEX_BITS class-store entries (65536 by default), with full
// held high; configuration writes are taken throughout. Write region_start
// last of the three registers: it also loads the bump pointer.
module size_class_block_allocator_unit #(
  parameter int GRANULE_INDEX_BITS = scba_pkg::GRANULE_INDEX_BITS,
  parameter int CLASS_COUNT = scba_pkg::CLASS_COUNT,
  parameter int QUEUE_DEPTH = scba_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                operation,
  input  logic [scba_pkg::ADDR_BITS-1:0]      request_size,
  input  logic [scba_pkg::ADDR_BITS-1:0]      block_address,
  output logic                                empty,
  input  logic                                pop,
  output logic [scba_pkg::ADDR_BITS-1:0]      result_address,
  output logic [scba_pkg::SIZE_BITS-1:0]      granted_size,
  output logic [1:0]                          status,
  input  logic                                cfg_write,
  input  logic [scba_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [scba_pkg::ADDR_BITS-1:0]      cfg_data
);

  localparam int CMD_W = $bits(scba_pkg::cmd_t) + GRANULE_INDEX_BITS;
  localparam int RES_W = $bits(scba_pkg::result_t);

  scba_pkg::cfg_t cfg;
  scba_pkg::cmd_t front_cmd;
  logic [GRANULE_INDEX_BITS-1:0] front_granule;
  scba_pkg::cmd_t mid_cmd;
  logic [GRANULE_INDEX_BITS-1:0] mid_granule;
  logic [CMD_W-1:0] mid_rdata;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  logic res_full;
  logic res_push;
  scba_pkg::result_t res_in;
  logic [RES_W-1:0] res_rdata;
  scba_pkg::result_t res_out;
  logic clearing;
  logic bump_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        scba_pkg::REG_REGION_START: cfg.region_start <= cfg_data;
        scba_pkg::REG_REGION_LIMIT: cfg.region_limit <= cfg_data;
        scba_pkg::REG_FRAME_WINDOW: cfg.frame_window_start <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bump_load = cfg_write && (cfg_index == scba_pkg::REG_REGION_START);
  assign full = mid_full || clearing;

  scba_front #(
    .GRANULE_INDEX_BITS(GRANULE_INDEX_BITS),
    .CLASS_COUNT(CLASS_COUNT)
  ) u_front (
    .operation(operation),
    .request_size(request_size),
    .block_address(block_address),
    .region_start(cfg.region_start),
    .cmd(front_cmd),
    .granule(front_granule)
  );

  scba_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk(clk),
    .rst(rst),
    .push(push && !full),
    .wdata({front_cmd, front_granule}),
    .full(mid_full),
    .pop(mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  assign {mid_cmd, mid_granule} = mid_rdata;

  scba_back #(
    .GRANULE_INDEX_BITS(GRANULE_INDEX_BITS),
    .CLASS_COUNT(CLASS_COUNT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .bump_load(bump_load),
    .bump_value(cfg_data),
    .cmd(mid_cmd),
    .cmd_granule(mid_granule),
    .cmd_empty(mid_empty),
    .cmd_pop(mid_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in),
    .clearing(clearing)
  );

  scba_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res_in),
    .full(res_full),
    .pop(pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign res_out = scba_pkg::result_t'(res_rdata);
  assign result_address = res_out.address;
  assign granted_size = res_out.size;
  assign status = res_out.status;

endmodule

/* rtl/scba_fifo.sv */
module scba_fifo #(
  parameter int WIDTH = $bits(scba_pkg::result_t),
  parameter int DEPTH = scba_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/scba_front.sv */
module scba_front #(
  parameter int GRANULE_INDEX_BITS = scba_pkg::GRANULE_INDEX_BITS,
  parameter int CLASS_COUNT = scba_pkg::CLASS_COUNT
) (
  input  logic                           operation,
  input  logic [scba_pkg::ADDR_BITS-1:0] request_size,
  input  logic [scba_pkg::ADDR_BITS-1:0] block_address,
  input  logic [scba_pkg::ADDR_BITS-1:0] region_start,
  output scba_pkg::cmd_t                 cmd,
  output logic [GRANULE_INDEX_BITS-1:0]  granule
);

  logic [scba_pkg::ADDR_BITS+1:0] off;
  logic too_large;
  logic [scba_pkg::CLASS_BITS-1:0] class_id;

  // smallest class that holds the request wins
  always_comb begin
    too_large = 1'b1;
    class_id = '0;
    for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
      if ({5'b0, scba_pkg::class_bytes(4'(k))} >= request_size) begin
        too_large = 1'b0;
        class_id = 4'(k);
      end
    end
  end

  assign off = {2'b00, block_address} - {2'b00, region_start}
               - 34'(scba_pkg::HDR_BYTES);
  assign granule = off[4 +: GRANULE_INDEX_BITS];

  always_comb begin
    cmd.op = operation;
    cmd.too_large = too_large;
    cmd.class_id = class_id;
    cmd.granule_ok = !off[33] && (off[3:0] == 4'd0)
                     && ((off[32:4] >> GRANULE_INDEX_BITS) == '0);
  end

endmodule

/* rtl/scba_back.sv */
module scba_back #(
  parameter int GRANULE_INDEX_BITS = scba_pkg::GRANULE_INDEX_BITS,
  parameter int CLASS_COUNT = scba_pkg::CLASS_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  scba_pkg::cfg_t                 cfg,
  input  logic                           bump_load,
  input  logic [scba_pkg::ADDR_BITS-1:0] bump_value,
  input  scba_pkg::cmd_t                 cmd,
  input  logic [GRANULE_INDEX_BITS-1:0]  cmd_granule,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  input  logic                           res_full,
  output logic                           res_push,
  output scba_pkg::result_t              res_data,
  output logic                           clearing
);

  localparam int IW = GRANULE_INDEX_BITS;
  localparam int KW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int DEPTH = 1 << GRANULE_INDEX_BITS;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LIST   = 6'b000100,
    S_BUMP_A = 6'b001000,
    S_BUMP_B = 6'b010000,
    S_FREE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IW-1:0] clr_idx;
  logic [scba_pkg::ADDR_BITS-1:0] bump;
  logic [CLASS_COUNT-1:0] head_valid;
  logic [IW-1:0] head [CLASS_COUNT];

  logic [KW-1:0] cur_class;
  logic [IW-1:0] cur_idx;
  logic [scba_pkg::SIZE_BITS-1:0] cur_size;
  logic [32:0] hdr;
  logic [32:0] end_sum;

  logic [scba_pkg::CLASS_BITS-1:0] class_mem [DEPTH];
  logic [IW-1:0] link_mem [DEPTH];
  logic [scba_pkg::CLASS_BITS-1:0] class_q;
  logic [IW-1:0] link_q;

  logic start;
  logic [KW-1:0] k_in;
  logic [scba_pkg::SIZE_BITS-1:0] size_in;
  logic [32:0] win_lo;
  logic [32:0] win_hi;
  logic in_win;
  logic [32:0] win_hdr;
  logic [32:0] bump_end;
  logic [33:0] hdr_off;
  logic bump_ok;
  logic [scba_pkg::CLASS_BITS-1:0] free_code;
  logic [KW-1:0] fk;
  logic code_ok;
  logic list_pop;
  logic free_push;

  logic cw_en;
  logic [IW-1:0] cw_addr;
  logic [scba_pkg::CLASS_BITS-1:0] cw_data;
  logic cr_en;
  logic lw_en;
  logic [IW-1:0] lw_data;
  logic lr_en;

  assign clearing = (state == S_CLEAR);
  assign start = (state == S_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop = start;
  assign k_in = cmd.class_id[KW-1:0];
  assign size_in = scba_pkg::class_bytes(cmd.class_id);

  assign win_lo = {1'b0, cfg.frame_window_start};
  assign win_hi = win_lo + 33'(scba_pkg::WINDOW_BYTES);
  assign in_win = (end_sum > win_lo) && (end_sum <= win_hi);
  assign win_hdr = (win_hi + 33'(scba_pkg::HDR_BYTES)) & ~33'h0_0000_000F;

  assign bump_end = hdr + 33'(scba_pkg::HDR_BYTES) + 33'(cur_size);
  assign hdr_off = {1'b0, hdr} - {2'b00, cfg.region_start};
  assign bump_ok = (bump_end <= {1'b0, cfg.region_limit}) && !hdr_off[33]
                   && (hdr_off[3:0] == 4'd0)
                   && ((hdr_off[32:4] >> GRANULE_INDEX_BITS) == '0);

  assign free_code = class_q - 4'd1;
  assign fk = free_code[KW-1:0];
  assign code_ok = (class_q != '0) && (class_q <= 4'(CLASS_COUNT));
  assign list_pop = (state == S_LIST);
  assign free_push = (state == S_FREE) && code_ok;
  assign lw_data = head_valid[fk] ? head[fk] : cur_idx;

  always_comb begin
    state_next = state;
    res_push = 1'b0;
    res_data = '{address: '0, size: '0, status: scba_pkg::STATUS_DONE};
    cw_en = 1'b0;
    cw_addr = hdr_off[4 +: IW];
    cw_data = 4'({1'b0, cur_class} + 1'b1);
    cr_en = 1'b0;
    lw_en = 1'b0;
    lr_en = 1'b0;
    case (state)
      S_CLEAR: begin
        cw_en = 1'b1;
        cw_addr = clr_idx;
        cw_data = '0;
        if (clr_idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (cmd.op == scba_pkg::OP_FREE) begin
            if (cmd.granule_ok) begin
              cr_en = 1'b1;
              state_next = S_FREE;
            end else begin
              res_push = 1'b1;
            end
          end else if (bump == '0) begin
            res_push = 1'b1;
            res_data.status = scba_pkg::STATUS_NO_HEAP;
          end else if (cmd.too_large) begin
            res_push = 1'b1;
            res_data.status = scba_pkg::STATUS_SIZE;
          end else if (head_valid[k_in]) begin
            lr_en = 1'b1;
            state_next = S_LIST;
          end else begin
            state_next = S_BUMP_A;
          end
        end
      end
      S_LIST: begin
        res_push = 1'b1;
        res_data.address = cfg.region_start + 32'({cur_idx, 4'b0000})
                           + 32'(scba_pkg::HDR_BYTES);
        res_data.size = cur_size;
        state_next = S_IDLE;
      end
      S_BUMP_A: begin
        state_next = S_BUMP_B;
      end
      S_BUMP_B: begin
        res_push = 1'b1;
        if (bump_ok) begin
          cw_en = 1'b1;
          res_data.address = hdr[31:0] + 32'(scba_pkg::HDR_BYTES);
          res_data.size = cur_size;
        end else begin
          res_data.status = scba_pkg::STATUS_NO_MEMORY;
        end
        state_next = S_IDLE;
      end
      S_FREE: begin
        res_push = 1'b1;
        lw_en = code_ok;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      bump <= '0;
      head_valid <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (bump_load) begin
        bump <= bump_value;
      end else if (state == S_BUMP_B) begin
        bump <= bump_end[31:0];
      end
      if (list_pop && (link_q == cur_idx)) begin
        head_valid[cur_class] <= 1'b0;
      end
      if (free_push) begin
        head_valid[fk] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_class <= k_in;
      cur_size <= size_in;
      cur_idx <= (cmd.op == scba_pkg::OP_FREE) ? cmd_granule : head[k_in];
      hdr <= {1'b0, bump};
      end_sum <= {1'b0, bump} + 33'(scba_pkg::HDR_BYTES) + 33'(size_in);
    end
    if ((state == S_BUMP_A) && in_win) begin
      hdr <= win_hdr;
    end
    if (list_pop && (link_q != cur_idx)) begin
      head[cur_class] <= link_q;
    end
    if (free_push) begin
      head[fk] <= cur_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      class_mem[cw_addr] <= cw_data;
    end
    if (cr_en) begin
      class_q <= class_mem[cmd_granule];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[cur_idx] <= lw_data;
    end
    if (lr_en) begin
      link_q <= link_mem[head[k_in]];
    end
  end

endmodule

/* rtl/scba_checker.sv */
module scba_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic [scba_pkg::ADDR_BITS-1:0]      result_address,
  input logic [scba_pkg::SIZE_BITS-1:0]      granted_size,
  input logic [1:0]                          status
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> full && empty)
    else $error("queues not held off after reset");

  a_fail_is_empty: assert property (@(posedge clk) disable iff (rst)
    !empty && (status != scba_pkg::STATUS_DONE) |->
      (result_address == '0) && (granted_size == '0))
    else $error("failed request carries an address or size");

  a_size_is_class: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $onehot0(granted_size))
    else $error("granted size is not a class size");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result_address)
      && $stable(granted_size) && $stable(status))
    else $error("waiting result changed");

endmodule

bind size_class_block_allocator_unit scba_checker u_checker (.*);

/* verif/tb_size_class_block_allocator_unit.sv */
module tb_size_class_block_allocator_unit;
  import scba_pkg::*;

  class alloc_tracker;
    bit [31:0] region_start;
    bit [31:0] region_limit;
    bit [31:0] window_start;
    bit [31:0] bump;
    bit head_ok [CLASS_COUNT];
    bit [GRANULE_INDEX_BITS-1:0] head_idx [CLASS_COUNT];
    bit [3:0] class_code [0:(1 << GRANULE_INDEX_BITS)-1];
    bit [GRANULE_INDEX_BITS-1:0] link_of [0:(1 << GRANULE_INDEX_BITS)-1];
    result_t pending_results [$];
    bit [31:0] live [$];
    int mismatches;

    function bit [SIZE_BITS-1:0] class_size(int k);
      case (k)
        0: return 27'h40;
        1: return 27'h400;
        2: return 27'h1000;
        3: return 27'h4000;
        4: return 27'h8000;
        default: return 27'h40000 << (k - 5);
      endcase
    endfunction

    function void report(string what);
      if (mismatches < 100) $display("MISMATCH %s", what);
      mismatches++;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
        REG_REGION_START: begin
          region_start = data;
          bump = data;
        end
        REG_REGION_LIMIT: region_limit = data;
        REG_FRAME_WINDOW: window_start = data;
        default: ;
      endcase
    endfunction

    function bit find_granule(logic [63:0] hdr, output bit [GRANULE_INDEX_BITS-1:0] g);
      logic [63:0] off;
      g = '0;
      if (hdr < {32'b0, region_start}) return 1'b0;
      off = hdr - {32'b0, region_start};
      if (off[3:0] != 4'd0) return 1'b0;
      off = off >> 4;
      if (off >= (64'd1 << GRANULE_INDEX_BITS)) return 1'b0;
      g = off[GRANULE_INDEX_BITS-1:0];
      return 1'b1;
    endfunction

    function void note_request(logic op, logic [31:0] req, logic [31:0] addr);
      result_t r;
      bit [GRANULE_INDEX_BITS-1:0] g;
      int k;
      bit [3:0] code;
      logic [63:0] hdr;
      logic [63:0] fin;
      logic [63:0] win;
      r.address = '0;
      r.size = '0;
      r.status = STATUS_DONE;
      if (op == OP_FREE) begin
        if (addr != 32'd0 && find_granule({32'b0, addr} - 64'(HDR_BYTES), g)) begin
          code = class_code[g];
          if (code != 4'd0 && code <= CLASS_COUNT) begin
            k = code - 1;
            link_of[g] = head_ok[k] ? head_idx[k] : g;
            head_idx[k] = g;
            head_ok[k] = 1'b1;
          end
        end
        pending_results.push_back(r);
        return;
      end
      k = 0;
      while (k < CLASS_COUNT && req > class_size(k)) k++;
      if (bump == 32'd0) begin
        r.status = STATUS_NO_HEAP;
      end else if (k == CLASS_COUNT) begin
        r.status = STATUS_SIZE;
      end else if (head_ok[k]) begin
        g = head_idx[k];
        if (link_of[g] == g) head_ok[k] = 1'b0;
        else head_idx[k] = link_of[g];
        hdr = {32'b0, region_start} + (64'(g) << 4);
        r.address = hdr[31:0] + 32'(HDR_BYTES);
        r.size = class_size(k);
      end else begin
        hdr = {32'b0, bump};
        fin = hdr + 64'(HDR_BYTES) + 64'(class_size(k));
        win = {32'b0, window_start};
        if (fin > win && fin <= win + 64'(WINDOW_BYTES)) begin
          hdr = (win + 64'(WINDOW_BYTES) + 64'(HDR_BYTES)) & ~64'hF;
          fin = hdr + 64'(HDR_BYTES) + 64'(class_size(k));
        end
        bump = fin[31:0];
        if (fin > {32'b0, region_limit} || !find_granule(hdr, g)) begin
          r.status = STATUS_NO_MEMORY;
        end else begin
          class_code[g] = 4'(k + 1);
          r.address = hdr[31:0] + 32'(HDR_BYTES);
          r.size = class_size(k);
        end
      end
      if (r.status == STATUS_DONE) live.push_back(r.address);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] a, logic [SIZE_BITS-1:0] s, logic [1:0] st);
      result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h/%h/%0d with no request pending", a, s, st));
        return;
      end
      e = pending_results.pop_front();
      if (a !== e.address)
        report($sformatf("result_address %h, expected %h", a, e.address));
      if (s !== e.size)
        report($sformatf("granted_size %h, expected %h", s, e.size));
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic operation;
  logic [ADDR_BITS-1:0] request_size;
  logic [ADDR_BITS-1:0] block_address;
  logic empty;
  logic pop;
  logic [ADDR_BITS-1:0] result_address;
  logic [SIZE_BITS-1:0] granted_size;
  logic [1:0] status;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [ADDR_BITS-1:0] cfg_data;

  bit push_calm;
  bit pop_calm;
  alloc_tracker allocator_state = new();

  size_class_block_allocator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .request_size(request_size),
    .block_address(block_address),
    .empty(empty),
    .pop(pop),
    .result_address(result_address),
    .granted_size(granted_size),
    .status(status),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) allocator_state.write_register(cfg_index, cfg_data);
      if (push && !full) allocator_state.note_request(operation, request_size, block_address);
      if (pop && !empty) allocator_state.check_result(result_address, granted_size, status);
    end
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_request(logic op, logic [31:0] size, logic [31:0] addr);
    int gap;
    gap = draw_wait(push_calm);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    request_size <= size;
    block_address <= addr;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (allocator_state.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_heap(logic [31:0] win, logic [31:0] lim, logic [31:0] start);
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WINDOW;
    cfg_data <= win;
    @(negedge clk);
    cfg_index <= REG_REGION_LIMIT;
    cfg_data <= lim;
    @(negedge clk);
    cfg_index <= REG_REGION_START;
    cfg_data <= start;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    int k;
    int i;
    logic [31:0] size;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    size = $urandom();
    addr = $urandom();
    if (pick < 62) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) k = $urandom_range(0, 2);
      else if (pick < 85) k = $urandom_range(0, 4);
      else if (pick < 90) k = $urandom_range(5, CLASS_COUNT - 1);
      else k = -1;
      if (k >= 0)
        size = $urandom_range(k == 0 ? 0 : allocator_state.class_size(k - 1) + 1,
                              allocator_state.class_size(k));
      else if (pick < 94) size = allocator_state.class_size($urandom_range(0, 4)) + 1;
      else if (pick < 97) size = $urandom_range(32'h0400_0001, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, size, addr);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 75 && allocator_state.live.size() > 0) begin
        i = $urandom_range(0, allocator_state.live.size() - 1);
        addr = allocator_state.live[i];
        // keep some blocks around so they get freed twice
        if ($urandom_range(0, 4) != 0) allocator_state.live.delete(i);
      end else if (pick < 85) begin
        addr = '0;
      end else if (pick < 95) begin
        addr = allocator_state.region_start + 32'd16 * ($urandom_range(0, 70000) + 1)
               + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0);
      end
      send_request(OP_FREE, size, addr);
    end
  endtask

  task automatic run_phase(logic [31:0] win, logic [31:0] lim, logic [31:0] start, int count);
    wait_idle();
    program_heap(win, lim, start);
    repeat (count) random_request();
  endtask

  task automatic random_phase(int count);
    logic [31:0] start;
    logic [31:0] lim;
    logic [31:0] win;
    logic [63:0] sum;
    start = $urandom() & 32'hFFFF_FFF0;
    if ($urandom_range(0, 5) == 0) start = start | $urandom_range(1, 15);
    if (start == 32'd0) start = 32'h100;
    sum = {32'b0, start} + 64'($urandom_range(32'h1000, 32'h18_0000));
    lim = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    case ($urandom_range(0, 2))
      0: win = $urandom();
      1: win = start - 32'h40_0000 + $urandom_range(0, 32'h10_0000);
      default: win = start + $urandom_range(0, 32'h8_0000);
    endcase
    run_phase(win, lim, start, count);
  endtask

  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      gap = draw_wait(pop_calm);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    operation = OP_ALLOC;
    request_size = '0;
    block_address = '0;
    cfg_write = 1'b0;
    cfg_index = REG_REGION_START;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_request(OP_ALLOC, 32'd0, $urandom());
    send_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom());
    send_request(OP_FREE, $urandom(), 32'd0);
    send_request(OP_FREE, $urandom(), 32'hFFFF_FFFF);

    wait_idle();
    program_heap(32'h8000_0000, 32'h1010_0000, 32'h1000_0000);
    send_request(OP_ALLOC, 32'd0, $urandom());
    send_request(OP_ALLOC, 32'd1, $urandom());
    send_request(OP_ALLOC, 32'h40, $urandom());
    send_request(OP_ALLOC, 32'h41, $urandom());
    send_request(OP_ALLOC, 32'h400, $urandom());
    send_request(OP_ALLOC, 32'h1000, $urandom());
    send_request(OP_ALLOC, 32'h4000, $urandom());
    send_request(OP_ALLOC, 32'h8000, $urandom());
    send_request(OP_ALLOC, 32'h8001, $urandom());
    send_request(OP_ALLOC, 32'h0400_0001, $urandom());
    send_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom());
    send_request(OP_FREE, $urandom(), allocator_state.live[0]);
    send_request(OP_FREE, $urandom(), allocator_state.live[0]);
    send_request(OP_ALLOC, 32'h40, $urandom());
    send_request(OP_ALLOC, 32'h40, $urandom());
    send_request(OP_ALLOC, 32'h40, $urandom());
    send_request(OP_FREE, $urandom(), 32'd0);
    send_request(OP_FREE, $urandom(), allocator_state.region_start + 32'd8);
    send_request(OP_FREE, $urandom(), allocator_state.region_start + 32'd16 * 5001);
    send_request(OP_ALLOC, 32'h0400_0000, $urandom());
    send_request(OP_ALLOC, 32'h40, $urandom());
    send_request(OP_FREE, $urandom(), allocator_state.live[1]);
    send_request(OP_ALLOC, 32'h3F, $urandom());

    run_phase(32'h8000_0000, 32'h1010_0000, 32'h1000_0000, 260);
    run_phase(32'h2000_0000, 32'h2050_0000, 32'h203F_E000, 260);
    run_phase(32'h2FC0_0100, 32'h0000_0000, 32'h3000_0008, 60);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
    run_phase(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 40);
    run_phase(32'h0000_0000, 32'h0050_0000, 32'h0040_0000, 200);
    repeat (3) random_phase(300);

    wait_idle();
    if (allocator_state.mismatches == 0 && allocator_state.pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #7_200_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
